// ===== sv/sv39ptw_pkg.sv =====
// Shared types and constants of the Sv39 page table walker.
package sv39ptw_pkg;

  localparam int PPN_W       = 44;
  localparam int PTE_W       = 54;
  localparam int VA_W        = 39;
  localparam int PA_W        = 56;
  localparam int VPN_W       = 9;
  localparam int OFFSET_W    = 12;
  localparam int PTE_PPN_LSB = 10;
  localparam int PTE_V_BIT   = 0;
  localparam int PTE_U_BIT   = 4;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_HIGH         = 3'd1,
    ST_MISSING      = 3'd2,
    ST_LEAF_INVALID = 3'd3,
    ST_NOT_USER     = 3'd4,
    ST_OUTSIDE      = 3'd5
  } status_e;

  typedef enum logic {
    FUNC_WRITE     = 1'b0,
    FUNC_TRANSLATE = 1'b1
  } func_e;

  typedef enum logic {
    CFG_ROOT_PAGE = 1'b0,
    CFG_MEM_BASE  = 1'b1
  } cfg_reg_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;       // an input beat is taken this cycle
    logic walk;         // check a directory entry and read the next level
    logic sel_l0;       // next level is the leaf level
    logic leaf;         // check the leaf entry
    logic out_load;     // load the output register
    logic res_load;     // park the finished result
    logic out_from_res; // output register takes the parked result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic done;         // the item finishes in this cycle
  } sts_t;

endpackage

// ===== sv/sv39ptw_ram.sv =====
// Generic single-port RAM with registered read data.
module sv39ptw_ram #(
  parameter int WIDTH = 54,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/sv39ptw_ctrl.sv =====
// Controller state machine of the Sv39 page table walker.
module sv39ptw_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sv39ptw_pkg::cmd_t  cmd_o,
  input  sv39ptw_pkg::sts_t  sts_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_L1,
    S_L0,
    S_LEAF,
    S_HOLD
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;
  logic   finish;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    finish  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.done) begin
            finish = 1'b1;
          end else begin
            state_d = S_L1;
          end
        end
      end
      S_L1: begin
        cmd_o.walk = 1'b1;
        if (sts_i.done) begin
          finish = 1'b1;
        end else begin
          state_d = S_L0;
        end
      end
      S_L0: begin
        cmd_o.walk   = 1'b1;
        cmd_o.sel_l0 = 1'b1;
        if (sts_i.done) begin
          finish = 1'b1;
        end else begin
          state_d = S_LEAF;
        end
      end
      S_LEAF: begin
        cmd_o.leaf = 1'b1;
        finish     = 1'b1;
      end
      S_HOLD: begin
        if (out_free) begin
          cmd_o.out_load     = 1'b1;
          cmd_o.out_from_res = 1'b1;
          state_d            = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // A finished result goes straight out when the output register is free.
    if (finish) begin
      if (out_free) begin
        cmd_o.out_load = 1'b1;
        state_d        = S_IDLE;
      end else begin
        cmd_o.res_load = 1'b1;
        state_d        = S_HOLD;
      end
    end

    out_valid_d = cmd_o.out_load || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== sv/sv39ptw_dpath.sv =====
// Datapath of the Sv39 page table walker: address checks, result and configuration registers.
module sv39ptw_dpath #(
  parameter int MEM_WORDS     = 4096,
  parameter int VA_LIMIT_BITS = 38,
  localparam int AW           = $clog2(MEM_WORDS)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  sv39ptw_pkg::cmd_t               cmd_i,
  output sv39ptw_pkg::sts_t               sts_o,
  input  logic                            cfg_we_i,
  input  logic                            cfg_index_i,
  input  logic [sv39ptw_pkg::PPN_W-1:0]   cfg_data_i,
  input  logic                            func_i,
  input  logic [11:0]                     word_index_i,
  input  logic [sv39ptw_pkg::PTE_W-1:0]   pte_word_i,
  input  logic [sv39ptw_pkg::VA_W-1:0]    virtual_address_i,
  output logic [sv39ptw_pkg::PA_W-1:0]    physical_address_o,
  output logic [2:0]                      status_o,
  output logic                            ram_en_o,
  output logic                            ram_we_o,
  output logic [AW-1:0]                   ram_addr_o,
  output logic [sv39ptw_pkg::PTE_W-1:0]   ram_wdata_o,
  input  logic [sv39ptw_pkg::PTE_W-1:0]   ram_rdata_i
);

  localparam int PPN_W  = sv39ptw_pkg::PPN_W;
  localparam int VPN_W  = sv39ptw_pkg::VPN_W;
  localparam int WORD_W = PPN_W + VPN_W;

  logic [PPN_W-1:0]            root_q, base_q;
  logic [2*VPN_W-1:0]          vpn_q;
  logic [sv39ptw_pkg::PA_W-1:0] res_pa_q, out_pa_q, fin_pa;
  sv39ptw_pkg::status_e        res_st_q, out_st_q, fin_st;

  logic             is_write, va_high, wr_ok;
  logic             l2_ok, nx_ok, ent_v, ent_u, done;
  logic [AW-1:0]    l2_addr, nx_addr, wr_addr;
  logic [PPN_W-1:0] ent_ppn;
  logic [VPN_W-1:0] nxt_idx;

  // Word address of a table entry relative to the window base; top bit flags a legal word.
  function automatic logic [AW:0] win(input logic [PPN_W-1:0] page,
                                      input logic [PPN_W-1:0] base,
                                      input logic [VPN_W-1:0] idx);
    logic [PPN_W:0]    diff;
    logic [WORD_W-1:0] word;
    diff = {1'b0, page} - {1'b0, base};
    word = {diff[PPN_W-1:0], idx};
    win  = {!diff[PPN_W] && (word < WORD_W'(MEM_WORDS)), word[AW-1:0]};
  endfunction

  always_comb begin
    is_write  = (sv39ptw_pkg::func_e'(func_i) == sv39ptw_pkg::FUNC_WRITE);
    va_high   = |(virtual_address_i >> VA_LIMIT_BITS);
    wr_ok     = (32'(word_index_i) < 32'(MEM_WORDS));
    wr_addr   = AW'(word_index_i);
    {l2_ok, l2_addr} = win(root_q, base_q, virtual_address_i[38:30]);

    ent_ppn = ram_rdata_i[sv39ptw_pkg::PTE_PPN_LSB +: PPN_W];
    ent_v   = ram_rdata_i[sv39ptw_pkg::PTE_V_BIT];
    ent_u   = ram_rdata_i[sv39ptw_pkg::PTE_U_BIT];
    nxt_idx = cmd_i.sel_l0 ? vpn_q[VPN_W-1:0] : vpn_q[2*VPN_W-1:VPN_W];
    {nx_ok, nx_addr} = win(ent_ppn, base_q, nxt_idx);

    ram_we_o    = cmd_i.accept && is_write && wr_ok;
    ram_en_o    = ram_we_o
                  || (cmd_i.accept && !is_write && !va_high && l2_ok)
                  || (cmd_i.walk && ent_v && nx_ok);
    ram_addr_o  = cmd_i.accept ? (is_write ? wr_addr : l2_addr) : nx_addr;
    ram_wdata_o = pte_word_i;

    done   = 1'b0;
    fin_pa = '0;
    fin_st = sv39ptw_pkg::ST_OK;
    if (cmd_i.accept) begin
      if (is_write) begin
        done = 1'b1;
      end else if (va_high) begin
        done   = 1'b1;
        fin_st = sv39ptw_pkg::ST_HIGH;
      end else if (!l2_ok) begin
        done   = 1'b1;
        fin_st = sv39ptw_pkg::ST_OUTSIDE;
      end
    end else if (cmd_i.walk) begin
      if (!ent_v) begin
        done   = 1'b1;
        fin_st = sv39ptw_pkg::ST_MISSING;
      end else if (!nx_ok) begin
        done   = 1'b1;
        fin_st = sv39ptw_pkg::ST_OUTSIDE;
      end
    end else if (cmd_i.leaf) begin
      done = 1'b1;
      if (!ent_v) begin
        fin_st = sv39ptw_pkg::ST_LEAF_INVALID;
      end else if (!ent_u) begin
        fin_st = sv39ptw_pkg::ST_NOT_USER;
      end else begin
        fin_pa = {ent_ppn, {sv39ptw_pkg::OFFSET_W{1'b0}}};
      end
    end
    sts_o.done = done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q <= '0;
      base_q <= '0;
    end else if (cfg_we_i) begin
      case (sv39ptw_pkg::cfg_reg_e'(cfg_index_i))
        sv39ptw_pkg::CFG_ROOT_PAGE: root_q <= cfg_data_i;
        sv39ptw_pkg::CFG_MEM_BASE:  base_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      vpn_q <= virtual_address_i[sv39ptw_pkg::OFFSET_W +: 2*VPN_W];
    end
    if (cmd_i.res_load) begin
      res_pa_q <= fin_pa;
      res_st_q <= fin_st;
    end
    if (cmd_i.out_load) begin
      out_pa_q <= cmd_i.out_from_res ? res_pa_q : fin_pa;
      out_st_q <= cmd_i.out_from_res ? res_st_q : fin_st;
    end
  end

  assign physical_address_o = out_pa_q;
  assign status_o           = out_st_q;

endmodule

// ===== sv/sv39_page_table_walker.sv =====
// Sv39 page table walker: write beats fill a local PTE memory, translate beats walk three levels.
// A write beat, or a translate beat that faults on its address or root window, finishes in the
// cycle it is accepted; a full walk finishes in the LEAF state after the L1 and L0 states, paced
// by three dependent reads of the single-port PTE memory, one per table level.
// The input is stalled for the whole walk; write beats are taken one per cycle while results drain.
// Reset clears the controller and both configuration registers; the PTE memory is not cleared.
module sv39_page_table_walker #(
  parameter int MEM_WORDS     = 4096,
  parameter int VA_LIMIT_BITS = 38
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,

  // Configuration write channel. Writes are always taken.
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic                           cfg_index_i,
  input  logic [sv39ptw_pkg::PPN_W-1:0]  cfg_data_i,

  // Input channel.
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           func_i,
  input  logic [11:0]                    word_index_i,
  input  logic [sv39ptw_pkg::PTE_W-1:0]  pte_word_i,
  input  logic [sv39ptw_pkg::VA_W-1:0]   virtual_address_i,

  // Result channel.
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [sv39ptw_pkg::PA_W-1:0]   physical_address_o,
  output logic [2:0]                     status_o
);

  localparam int AW = $clog2(MEM_WORDS);

  sv39ptw_pkg::cmd_t             cmd;
  sv39ptw_pkg::sts_t             sts;
  logic                          ram_en, ram_we;
  logic [AW-1:0]                 ram_addr;
  logic [sv39ptw_pkg::PTE_W-1:0] ram_wdata, ram_rdata;

  // Only change the registers while the block is idle; it does not enforce this or push back.
  assign cfg_ready_o = 1'b1;

  // The controller sequences the walk: it takes a beat in its idle state, spends one state per
  // remaining table level, and parks a finished result when the output register is still
  // occupied. While a result is parked the input is stalled; it opens again once the parked
  // result has moved into the output register.
  sv39ptw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // The datapath forms each table word address from a page number and a nine-bit index,
  // checks it against the memory window, inspects the entry that comes back and builds the
  // result. The root level address comes straight from the input beat, so the first read
  // is issued in the cycle the beat is accepted.
  sv39ptw_dpath #(
    .MEM_WORDS     (MEM_WORDS),
    .VA_LIMIT_BITS (VA_LIMIT_BITS)
  ) u_dpath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .cfg_we_i           (cfg_valid_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .func_i             (func_i),
    .word_index_i       (word_index_i),
    .pte_word_i         (pte_word_i),
    .virtual_address_i  (virtual_address_i),
    .physical_address_o (physical_address_o),
    .status_o           (status_o),
    .ram_en_o           (ram_en),
    .ram_we_o           (ram_we),
    .ram_addr_o         (ram_addr),
    .ram_wdata_o        (ram_wdata),
    .ram_rdata_i        (ram_rdata)
  );

  // PTE store: one port, shared by write beats and the table reads of a walk.
  sv39ptw_ram #(
    .WIDTH (sv39ptw_pkg::PTE_W),
    .DEPTH (MEM_WORDS)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // A faulting result never carries an address.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != sv39ptw_pkg::ST_OK)) |-> (physical_address_o == '0))
    else $error("faulting result carries a non-zero address");

  // Translated addresses are always page aligned.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (physical_address_o[sv39ptw_pkg::OFFSET_W-1:0] == '0))
    else $error("result address is not page aligned");

  // A result that is held back downstream is never overwritten by the controller.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> !cmd.out_load)
    else $error("output register loaded while its beat is stalled");

  // Results are either sent at once or parked, never both.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.out_load && cmd.res_load))
    else $error("result both loaded and parked");

endmodule

// ===== tb/sv39_page_table_walker_tb.sv =====
// Self-checking testbench for the Sv39 page table walker: directed walks, then random table builds.
import sv39ptw_pkg::*;

module sv39_page_table_walker_tb;

  localparam int MEM_WORDS      = 4096;
  localparam int VA_LIMIT_BITS  = 38;
  localparam int DRAIN_CYCLES   = 10;   // outlasts a full walk after the last beat
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_PRINTED    = 50;

  localparam logic [PPN_W-1:0] PAGE_MAX = {PPN_W{1'b1}};
  localparam logic [9:0]       PTE_V    = 10'(1) << PTE_V_BIT;
  localparam logic [9:0]       PTE_U    = 10'(1) << PTE_U_BIT;

  // Keeps its own copy of the registers and of the PTE memory, predicts the result of every
  // accepted input beat and compares result beats against the oldest prediction.
  class sv39_walk_board #(int WORDS = 4096, int VA_LIMIT = 38);
    logic [PPN_W-1:0] root_page;
    logic [PPN_W-1:0] mem_base;
    logic [PTE_W-1:0] pte_mem [WORDS];
    bit               written [WORDS];
    logic [PA_W-1:0]  expected_pa [$];
    status_e          expected_status [$];

    function new();
      root_page = '0;
      mem_base  = '0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [PPN_W-1:0] val);
      case (idx)
        CFG_ROOT_PAGE: root_page = val;
        CFG_MEM_BASE:  mem_base  = val;
        default:       ;
      endcase
    endfunction

    // Local word address of entry idx in table page page; 0 when the page lies outside the
    // window of local memory.
    function bit word_of(logic [PPN_W-1:0] page, logic [VPN_W-1:0] idx, output int unsigned w);
      longint unsigned diff;
      w = 0;
      if (page < mem_base) return 1'b0;
      diff = page - mem_base;
      if (diff >= WORDS) return 1'b0;
      diff = diff * 512 + idx;
      if (diff >= WORDS) return 1'b0;
      w = int'(diff);
      return 1'b1;
    endfunction

    // Three-level walk. clean stays set only if every word read has been written before.
    function void walk(logic [VA_W-1:0] va, output logic [PA_W-1:0] pa, output status_e st,
                       output bit clean);
      logic [PPN_W-1:0] page;
      logic [PTE_W-1:0] entry;
      int unsigned      w;
      pa    = '0;
      st    = ST_OK;
      clean = 1'b1;
      page  = root_page;
      entry = '0;
      if ((va >> VA_LIMIT) != 0) begin
        st = ST_HIGH;
        return;
      end
      for (int lvl = 2; lvl >= 0; lvl--) begin
        if (!word_of(page, va[OFFSET_W + VPN_W * lvl +: VPN_W], w)) begin
          st = ST_OUTSIDE;
          return;
        end
        clean = clean && written[w];
        entry = pte_mem[w];
        if (!entry[PTE_V_BIT]) begin
          st = (lvl == 0) ? ST_LEAF_INVALID : ST_MISSING;
          return;
        end
        page = entry[PTE_PPN_LSB +: PPN_W];
      end
      if (!entry[PTE_U_BIT]) begin
        st = ST_NOT_USER;
      end else begin
        pa = {page, {OFFSET_W{1'b0}}};
      end
    endfunction

    function void note_beat(func_e f, logic [11:0] widx, logic [PTE_W-1:0] pte,
                            logic [VA_W-1:0] va);
      logic [PA_W-1:0] pa;
      status_e         st;
      bit              clean;
      pa = '0;
      st = ST_OK;
      if (f == FUNC_WRITE) begin
        if (widx < WORDS) begin
          pte_mem[widx] = pte;
          written[widx] = 1'b1;
        end
      end else begin
        walk(va, pa, st, clean);
      end
      expected_pa.push_back(pa);
      expected_status.push_back(st);
    endfunction

    function bit check_result(logic [PA_W-1:0] pa, logic [2:0] st, output string why);
      logic [PA_W-1:0] want_pa;
      status_e         want_st;
      why = "";
      if (expected_pa.size() == 0) begin
        why = $sformatf("result beat with nothing outstanding: pa %h status %0d", pa, st);
        return 1'b0;
      end
      want_pa = expected_pa.pop_front();
      want_st = expected_status.pop_front();
      if (st !== want_st)
        why = $sformatf("status %0d, expected %0d (%s); ", st, want_st, want_st.name());
      if (pa !== want_pa)
        why = {why, $sformatf("physical address %h, expected %h", pa, want_pa)};
      return why == "";
    endfunction

    function int outstanding();
      return expected_pa.size();
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni            = 1'b0;
  logic               cfg_valid_i       = 1'b0;
  logic               cfg_ready_o;
  logic               cfg_index_i       = 1'b0;
  logic [PPN_W-1:0]   cfg_data_i        = '0;
  logic               in_valid_i        = 1'b0;
  logic               in_stall_o;
  logic               func_i            = 1'b0;
  logic [11:0]        word_index_i      = '0;
  logic [PTE_W-1:0]   pte_word_i        = '0;
  logic [VA_W-1:0]    virtual_address_i = '0;
  logic               out_valid_o;
  logic               out_stall_i       = 1'b0;
  logic [PA_W-1:0]    physical_address_o;
  logic [2:0]         status_o;

  sv39_walk_board #(MEM_WORDS, VA_LIMIT_BITS) sb;

  int               mismatches     = 0;
  int               beats_sent     = 0;
  int               burst_left     = 0;
  int               pressure_beats = 0;
  bit               hold_request   = 1'b0;
  int               quiet_cycles   = 0;
  logic [PPN_W-1:0] cur_root       = '0;
  logic [PPN_W-1:0] cur_base       = '0;

  sv39_page_table_walker #(
    .MEM_WORDS     (MEM_WORDS),
    .VA_LIMIT_BITS (VA_LIMIT_BITS)
  ) dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTED) $display("mismatch at %0t: %s", $time, msg);
  endtask

  function automatic logic [63:0] rand_bits();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [VA_W-1:0] va_of(logic [8:0] v2, logic [8:0] v1, logic [8:0] v0,
                                            logic [11:0] off);
    return {v2, v1, v0, off};
  endfunction

  // Most table pages fall inside the eight-page window of local memory; the rest are anywhere.
  function automatic logic [PPN_W-1:0] table_page();
    if ($urandom_range(0, 99) < 85) return cur_base + PPN_W'($urandom_range(0, 7));
    return PPN_W'(rand_bits());
  endfunction

  // Offers one input beat and returns at the clock edge that accepts it. The sender works in
  // bursts; between bursts valid drops for a random gap. While the pressure stretch is running
  // no gap is inserted, so the walker fills up behind the held-off result channel.
  task automatic send_item(func_e f, logic [11:0] widx, logic [PTE_W-1:0] pte,
                           logic [VA_W-1:0] va);
    int gap;
    if (pressure_beats > 0) begin
      pressure_beats--;
    end else if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 32);
    end else begin
      burst_left--;
    end
    in_valid_i        <= 1'b1;
    func_i            <= f;
    word_index_i      <= widx;
    pte_word_i        <= pte;
    virtual_address_i <= va;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sb.note_beat(f, widx, pte, va);
    beats_sent++;
  endtask

  task automatic send_write(logic [11:0] widx, logic [PTE_W-1:0] pte);
    send_item(FUNC_WRITE, widx, pte, VA_W'(rand_bits()));
  endtask

  // A translation is only offered if its walk reads no word that has never been written.
  task automatic try_translate(logic [VA_W-1:0] va);
    logic [PA_W-1:0] pa;
    status_e         st;
    bit              clean;
    sb.walk(va, pa, st, clean);
    if (clean) send_item(FUNC_TRANSLATE, 12'($urandom), PTE_W'(rand_bits()), va);
  endtask

  // Lets every outstanding result drain, plus the walker's latency, before a register write.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [PPN_W-1:0] val);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    sb.set_reg(idx, val);
    if (idx == CFG_ROOT_PAGE) cur_root = val;
    else cur_base = val;
  endtask

  // A well-formed table build: a root entry, a directory entry and a leaf, each written with
  // random flags (the first two point to a mostly in-window page), then one or two translations
  // through them. Now and then a level is left out, which breaks the chain.
  task automatic walk_sequence();
    logic [8:0]       v2;
    logic [8:0]       v1;
    logic [8:0]       v0;
    logic [PPN_W-1:0] pg1;
    logic [PPN_W-1:0] pg0;
    logic [9:0]       fl;
    int unsigned      w;
    v2  = ($urandom_range(0, 11) == 0) ? 9'($urandom_range(256, 511))
                                       : 9'($urandom_range(0, 255));
    v1  = 9'($urandom);
    v0  = 9'($urandom);
    pg1 = table_page();
    pg0 = table_page();
    fl  = 10'($urandom);
    fl[PTE_V_BIT] = ($urandom_range(0, 9) != 0);
    if (sb.word_of(cur_root, v2, w) && $urandom_range(0, 11) != 0)
      send_write(12'(w), {pg1, fl});
    fl = 10'($urandom);
    fl[PTE_V_BIT] = ($urandom_range(0, 9) != 0);
    if (sb.word_of(pg1, v1, w) && $urandom_range(0, 11) != 0)
      send_write(12'(w), {pg0, fl});
    fl = 10'($urandom);
    fl[PTE_V_BIT] = ($urandom_range(0, 7) != 0);
    fl[PTE_U_BIT] = ($urandom_range(0, 6) != 0);
    if (sb.word_of(pg0, v0, w) && $urandom_range(0, 11) != 0)
      send_write(12'(w), {PPN_W'(rand_bits()), fl});
    repeat ($urandom_range(1, 2)) try_translate(va_of(v2, v1, v0, 12'($urandom)));
  endtask

  // A fully random address; if no clean walk turns up, an address above the limit is sent.
  task automatic random_translate();
    logic [VA_W-1:0] va;
    logic [PA_W-1:0] pa;
    status_e         st;
    bit              clean;
    for (int tries = 0; tries < 8; tries++) begin
      va = VA_W'(rand_bits());
      if ($urandom_range(0, 99) < 85) va[VA_W-1] = 1'b0;
      sb.walk(va, pa, st, clean);
      if (clean) begin
        send_item(FUNC_TRANSLATE, 12'($urandom), PTE_W'(rand_bits()), va);
        return;
      end
    end
    va = VA_W'(rand_bits());
    va[VA_W-1] = 1'b1;
    try_translate(va);
  endtask

  // The result side stalls on a pattern of its own: segments of random length, each with its
  // own stall rate, some of them with no stall at all. On request it holds off for a long run.
  initial begin : result_sink
    int seg_left;
    int pct;
    int hold_left;
    seg_left  = 0;
    pct       = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
        out_stall_i <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(10, 150);
          case ($urandom_range(0, 3))
            0:       pct = 0;
            1:       pct = 20;
            2:       pct = 50;
            default: pct = 85;
          endcase
        end
        seg_left--;
        out_stall_i <= ($urandom_range(0, 99) < pct);
      end
    end
  end

  // Every result beat is checked as it is accepted.
  always @(posedge clk_i) begin
    string why;
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i)
      if (!sb.check_result(physical_address_o, status_o, why)) report_mismatch(why);
  end

  // The run is declared hung when no beat moves on any channel for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i)
        || (cfg_valid_i && cfg_ready_o === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [PPN_W-1:0] phase_root [7];
    logic [PPN_W-1:0] phase_base [7];
    int               phase_beats [7];
    logic [PPN_W-1:0] rb;
    int               goal;
    int               pick;
    bit               pressure_done;

    sb = new();
    pressure_done = 1'b0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, run on the register values left by reset: root page 0, window from page 0.
    // A complete walk to the largest page number.
    send_write(12'd0, {PPN_W'(1), PTE_V});
    send_write(12'd512, {PPN_W'(2), PTE_V});
    send_write(12'd1024, {PAGE_MAX, PTE_V | PTE_U});
    try_translate(va_of(9'd0, 9'd0, 9'd0, 12'hFFF));
    // Addresses at and above the limit.
    try_translate(VA_W'(1) << VA_LIMIT_BITS);
    try_translate({VA_W{1'b1}});
    // Invalid root entry, reached by the highest root index still below the limit.
    send_write(12'd255, '0);
    try_translate(va_of(9'd255, 9'd511, 9'd511, 12'd0));
    // Invalid directory entry carrying every other flag.
    send_write(12'd513, {PPN_W'(3), ~PTE_V});
    try_translate(va_of(9'd0, 9'd1, 9'd0, 12'd0));
    // Leaf with the user bit but no valid bit.
    send_write(12'd1025, {PPN_W'(5), PTE_U});
    try_translate(va_of(9'd0, 9'd0, 9'd1, 12'd0));
    // Valid leaf with every flag except user.
    send_write(12'd1026, {PPN_W'(6), ~PTE_U});
    try_translate(va_of(9'd0, 9'd0, 9'd2, 12'd0));
    // The next table page falls just past the window, and far past it at the leaf level.
    send_write(12'd2, {PPN_W'(8), PTE_V});
    try_translate(va_of(9'd2, 9'd0, 9'd0, 12'd0));
    send_write(12'd515, {PAGE_MAX, PTE_V});
    try_translate(va_of(9'd0, 9'd3, 9'd0, 12'd0));
    // A walk ending in the last word of memory, which holds an all-ones entry.
    send_write(12'd5, {PPN_W'(7), PTE_V});
    send_write(12'd3590, {PPN_W'(7), PTE_V});
    send_write(12'd4095, {PTE_W{1'b1}});
    try_translate(va_of(9'd5, 9'd6, 9'd511, 12'hABC));

    // Random phases, each with its own register setting: the reset values, both registers at
    // their maximum, the window at the top of the page space, a random window, a root below
    // the window, the root at the last window page, and a root far outside.
    rb = PPN_W'(rand_bits());
    phase_root[0] = '0;                phase_base[0] = '0;                phase_beats[0] = 420;
    phase_root[1] = PAGE_MAX;          phase_base[1] = PAGE_MAX;          phase_beats[1] = 300;
    phase_root[2] = PAGE_MAX - 2;      phase_base[2] = PAGE_MAX - 7;      phase_beats[2] = 300;
    phase_root[3] = rb + PPN_W'($urandom_range(0, 7));
    phase_base[3] = rb;                                                   phase_beats[3] = 300;
    rb = PPN_W'(rand_bits()) | PPN_W'(1);
    phase_root[4] = rb - 1;            phase_base[4] = rb;                phase_beats[4] = 120;
    phase_root[5] = PPN_W'(7);         phase_base[5] = '0;                phase_beats[5] = 300;
    phase_root[6] = PAGE_MAX;          phase_base[6] = PPN_W'(rand_bits()) >> 1;
    phase_beats[6] = 100;

    for (int p = 0; p < 7; p++) begin
      write_reg(CFG_ROOT_PAGE, phase_root[p]);
      write_reg(CFG_MEM_BASE, phase_base[p]);
      goal = beats_sent + phase_beats[p];
      while (beats_sent < goal) begin
        // Once in the first phase the result side holds off for a long run while beats keep
        // coming, so the walker backs up to its input.
        if (!pressure_done && beats_sent >= goal - phase_beats[p] / 2) begin
          pressure_done  = 1'b1;
          hold_request   = 1'b1;
          pressure_beats = 40;
        end
        pick = $urandom_range(0, 99);
        if (pick < 55) walk_sequence();
        else if (pick < 70) random_translate();
        else send_write(12'($urandom), PTE_W'(rand_bits()));
      end
    end

    wait_drained();
    if (mismatches == 0 && sb.outstanding() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
